FILE: rtl/core/dmsr_pkg.sv
// shared types, constants and helpers for the dual motor slew ramp drive
package dmsr_pkg;

	// apb address width: three 32-bit registers at 0, 4 and 8
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
	localparam logic [1:0] REG_CLIMB_SPEED = 2'd1;
	localparam logic [1:0] REG_RAMP_STEP   = 2'd2;

	// register limits and reset values
	localparam logic [7:0] FULL_SCALE      = 8'd255;
	localparam logic [7:0] MAX_SPEED_FLOOR = 8'd50;
	localparam logic [7:0] RAMP_STEP_RESET = 8'd10;
	localparam logic [7:0] RAMP_STEP_MIN   = 8'd1;

	// current speed magnitude above which the drive counts as moving
	localparam logic [8:0] MOVING_LIMIT = 9'd5;

	// command codes
	typedef enum logic [3:0] {
		OP_TICK       = 4'd0,
		OP_STOP       = 4'd1,
		OP_FORWARD    = 4'd2,
		OP_BACKWARD   = 4'd3,
		OP_TURN_LEFT  = 4'd4,
		OP_TURN_RIGHT = 4'd5,
		OP_CLIMB      = 4'd6,
		OP_SET_SPEEDS = 4'd7,
		OP_ESTOP      = 4'd8
	} op_t;

	// configuration register contents
	typedef struct packed {
		logic [7:0] max_speed;
		logic [7:0] climb_speed;
		logic [7:0] ramp_step;
	} cfg_t;

	// per-request control from the command decoder
	typedef struct packed {
		logic tick;
		logic estop;
	} cmd_ctl_t;

	// magnitude of a 9-bit signed speed
	function automatic logic [8:0] mag9(input logic signed [8:0] v);
		logic [8:0] r;
		r = v[8] ? 9'(-v) : 9'(v);
		return r;
	endfunction

	// bridge duty: magnitude saturated to full scale
	function automatic logic [7:0] duty_of(input logic signed [8:0] v);
		logic [8:0] m;
		m = mag9(v);
		return m[8] ? FULL_SCALE : m[7:0];
	endfunction

endpackage

FILE: rtl/core/dmsr_regs.sv
// apb configuration registers with write-side clamping
module dmsr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dmsr_pkg::ADDR_W-1:0] paddr,
	input  logic [dmsr_pkg::DATA_W-1:0] pwdata,
	output logic [dmsr_pkg::DATA_W-1:0] prdata,
	output dmsr_pkg::cfg_t              cfg
);

	logic [7:0] max_speed_q;
	logic [7:0] climb_speed_q;
	logic [7:0] ramp_step_q;
	logic [7:0] wr_byte;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign wr_byte = pwdata[7:0];
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	// register writes, clamped to their legal ranges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q   <= dmsr_pkg::FULL_SCALE;
			climb_speed_q <= dmsr_pkg::FULL_SCALE;
			ramp_step_q   <= dmsr_pkg::RAMP_STEP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				dmsr_pkg::REG_MAX_SPEED: begin
					max_speed_q <= (wr_byte < dmsr_pkg::MAX_SPEED_FLOOR) ?
						dmsr_pkg::MAX_SPEED_FLOOR : wr_byte;
				end
				dmsr_pkg::REG_CLIMB_SPEED: begin
					climb_speed_q <= (wr_byte < max_speed_q) ? max_speed_q : wr_byte;
				end
				dmsr_pkg::REG_RAMP_STEP: begin
					ramp_step_q <= (wr_byte < dmsr_pkg::RAMP_STEP_MIN) ?
						dmsr_pkg::RAMP_STEP_MIN : wr_byte;
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			dmsr_pkg::REG_MAX_SPEED:   prdata = {24'd0, max_speed_q};
			dmsr_pkg::REG_CLIMB_SPEED: prdata = {24'd0, climb_speed_q};
			dmsr_pkg::REG_RAMP_STEP:   prdata = {24'd0, ramp_step_q};
			default:                   prdata = '0;
		endcase
	end

	assign cfg.max_speed   = max_speed_q;
	assign cfg.climb_speed = climb_speed_q;
	assign cfg.ramp_step   = ramp_step_q;

endmodule

FILE: rtl/core/dmsr_cmd.sv
// command decode: target speeds, emergency latch and tick/estop control
module dmsr_cmd (
	input  dmsr_pkg::op_t        op,
	input  logic signed [8:0]    speed_a,
	input  logic signed [8:0]    speed_b,
	input  dmsr_pkg::cfg_t       cfg,
	input  logic                 latch,
	input  logic signed [8:0]    left_target,
	input  logic signed [8:0]    right_target,
	output logic signed [8:0]    left_target_nxt,
	output logic signed [8:0]    right_target_nxt,
	output logic                 latch_nxt,
	output dmsr_pkg::cmd_ctl_t   ctl
);

	logic signed [8:0] max_s;
	logic signed [8:0] neg_max_s;
	logic signed [8:0] climb_s;
	logic signed [8:0] fwd_s;
	logic signed [8:0] neg_s;
	logic signed [8:0] climb_v;
	logic signed [8:0] set_a;
	logic signed [8:0] set_b;

	assign max_s     = $signed({1'b0, cfg.max_speed});
	assign neg_max_s = -max_s;
	assign climb_s   = $signed({1'b0, cfg.climb_speed});

	// single-speed clamps to zero..limit
	assign fwd_s   = speed_a[8] ? 9'sd0 : ((speed_a > max_s) ? max_s : speed_a);
	assign neg_s   = -fwd_s;
	assign climb_v = speed_a[8] ? 9'sd0 : ((speed_a > climb_s) ? climb_s : speed_a);

	// symmetric clamps for set speeds
	assign set_a = (speed_a < neg_max_s) ? neg_max_s :
		((speed_a > max_s) ? max_s : speed_a);
	assign set_b = (speed_b < neg_max_s) ? neg_max_s :
		((speed_b > max_s) ? max_s : speed_b);

	// next targets and latch per command
	always_comb begin
		left_target_nxt  = left_target;
		right_target_nxt = right_target;
		latch_nxt        = latch;
		ctl.tick         = 1'b0;
		ctl.estop        = 1'b0;
		case (op)
			dmsr_pkg::OP_TICK: begin
				ctl.tick = 1'b1;
			end
			dmsr_pkg::OP_STOP: begin
				left_target_nxt  = '0;
				right_target_nxt = '0;
				latch_nxt        = 1'b0;
			end
			dmsr_pkg::OP_FORWARD: begin
				if (!latch) begin
					left_target_nxt  = fwd_s;
					right_target_nxt = fwd_s;
				end
			end
			dmsr_pkg::OP_BACKWARD: begin
				if (!latch) begin
					left_target_nxt  = neg_s;
					right_target_nxt = neg_s;
				end
			end
			dmsr_pkg::OP_TURN_LEFT: begin
				if (!latch) begin
					left_target_nxt  = neg_s;
					right_target_nxt = fwd_s;
				end
			end
			dmsr_pkg::OP_TURN_RIGHT: begin
				if (!latch) begin
					left_target_nxt  = fwd_s;
					right_target_nxt = neg_s;
				end
			end
			dmsr_pkg::OP_CLIMB: begin
				if (!latch) begin
					left_target_nxt  = climb_v;
					right_target_nxt = climb_v;
				end
			end
			dmsr_pkg::OP_SET_SPEEDS: begin
				if (!latch) begin
					left_target_nxt  = set_a;
					right_target_nxt = set_b;
				end
			end
			dmsr_pkg::OP_ESTOP: begin
				left_target_nxt  = '0;
				right_target_nxt = '0;
				latch_nxt        = 1'b1;
				ctl.estop        = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/dmsr_ramp.sv
// one channel slew limiter: step current speed toward target
module dmsr_ramp (
	input  logic signed [8:0] cur,
	input  logic signed [8:0] tgt,
	input  logic [7:0]        step,
	output logic signed [8:0] nxt
);

	logic signed [9:0] diff;
	logic [9:0]        gap;
	logic signed [8:0] step_s;

	assign diff   = $signed({tgt[8], tgt}) - $signed({cur[8], cur});
	assign gap    = diff[9] ? 10'(-diff) : 10'(diff);
	assign step_s = $signed({1'b0, step});

	// snap when within one step, else move by one step
	always_comb begin
		if (gap <= {2'b00, step}) begin
			nxt = tgt;
		end else if (!diff[9]) begin
			nxt = cur + step_s;
		end else begin
			nxt = cur - step_s;
		end
	end

endmodule

FILE: rtl/core/dual_motor_slew_ramp_drive_unit.sv
// top level: dual motor slew ramp drive with apb configuration
// a request waits in the input register until the result register is free, then its result is registered there
// throughput: one request per cycle while the sink keeps up; the state update is a single
// compare and add per channel between the input register and the result register
// reset: targets, current speeds and drives clear, latch clear, registers to defaults
module dual_motor_slew_ramp_drive_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  opcode,
	input  logic signed [8:0]           speed_a,
	input  logic signed [8:0]           speed_b,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  left_duty,
	output logic                        left_reverse,
	output logic [7:0]                  right_duty,
	output logic                        right_reverse,
	output logic signed [8:0]           left_now,
	output logic signed [8:0]           right_now,
	output logic                        moving,
	output logic                        halted,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dmsr_pkg::ADDR_W-1:0] paddr,
	input  logic [dmsr_pkg::DATA_W-1:0] pwdata,
	output logic [dmsr_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	dmsr_pkg::cfg_t     cfg;
	dmsr_pkg::cmd_ctl_t ctl;

	// input stage
	logic              valid_s1;
	dmsr_pkg::op_t     op_s1;
	logic signed [8:0] speed_a_s1;
	logic signed [8:0] speed_b_s1;

	// drive state
	logic signed [8:0] left_target_q;
	logic signed [8:0] right_target_q;
	logic signed [8:0] left_current_q;
	logic signed [8:0] right_current_q;
	logic signed [8:0] left_drive_q;
	logic signed [8:0] right_drive_q;
	logic              latch_q;

	// next state
	logic signed [8:0] left_target_nxt;
	logic signed [8:0] right_target_nxt;
	logic              latch_nxt;
	logic signed [8:0] left_ramp;
	logic signed [8:0] right_ramp;
	logic signed [8:0] left_current_nxt;
	logic signed [8:0] right_current_nxt;
	logic signed [8:0] left_drive_nxt;
	logic signed [8:0] right_drive_nxt;

	// result register
	logic              out_valid_q;
	logic [7:0]        left_duty_q;
	logic              left_reverse_q;
	logic [7:0]        right_duty_q;
	logic              right_reverse_q;
	logic signed [8:0] left_now_q;
	logic signed [8:0] right_now_q;
	logic              moving_q;
	logic              halted_q;

	logic advance;

	assign pready = 1'b1;

	dmsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// handshake: the input stage moves on when the result register is empty or being taken by the sink
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= dmsr_pkg::op_t'(opcode);
			speed_a_s1 <= speed_a;
			speed_b_s1 <= speed_b;
		end
	end

	dmsr_cmd u_cmd (
		.op               (op_s1),
		.speed_a          (speed_a_s1),
		.speed_b          (speed_b_s1),
		.cfg              (cfg),
		.latch            (latch_q),
		.left_target      (left_target_q),
		.right_target     (right_target_q),
		.left_target_nxt  (left_target_nxt),
		.right_target_nxt (right_target_nxt),
		.latch_nxt        (latch_nxt),
		.ctl              (ctl)
	);

	dmsr_ramp u_ramp_left (
		.cur  (left_current_q),
		.tgt  (left_target_q),
		.step (cfg.ramp_step),
		.nxt  (left_ramp)
	);

	dmsr_ramp u_ramp_right (
		.cur  (right_current_q),
		.tgt  (right_target_q),
		.step (cfg.ramp_step),
		.nxt  (right_ramp)
	);

	// current speed and drive update
	always_comb begin
		left_current_nxt  = left_current_q;
		right_current_nxt = right_current_q;
		left_drive_nxt    = left_drive_q;
		right_drive_nxt   = right_drive_q;
		if (ctl.estop) begin
			left_current_nxt  = '0;
			right_current_nxt = '0;
			left_drive_nxt    = '0;
			right_drive_nxt   = '0;
		end else if (ctl.tick) begin
			left_current_nxt  = left_ramp;
			right_current_nxt = right_ramp;
			if (!latch_q) begin
				left_drive_nxt  = left_ramp;
				right_drive_nxt = right_ramp;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_target_q   <= '0;
			right_target_q  <= '0;
			left_current_q  <= '0;
			right_current_q <= '0;
			left_drive_q    <= '0;
			right_drive_q   <= '0;
			latch_q         <= 1'b0;
		end else if (advance) begin
			left_target_q   <= left_target_nxt;
			right_target_q  <= right_target_nxt;
			left_current_q  <= left_current_nxt;
			right_current_q <= right_current_nxt;
			left_drive_q    <= left_drive_nxt;
			right_drive_q   <= right_drive_nxt;
			latch_q         <= latch_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			left_duty_q     <= dmsr_pkg::duty_of(left_drive_nxt);
			left_reverse_q  <= left_drive_nxt[8];
			right_duty_q    <= dmsr_pkg::duty_of(right_drive_nxt);
			right_reverse_q <= right_drive_nxt[8];
			left_now_q      <= left_current_nxt;
			right_now_q     <= right_current_nxt;
			moving_q        <= (dmsr_pkg::mag9(left_current_nxt) > dmsr_pkg::MOVING_LIMIT) |
				(dmsr_pkg::mag9(right_current_nxt) > dmsr_pkg::MOVING_LIMIT);
			halted_q        <= latch_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_duty     = left_duty_q;
	assign left_reverse  = left_reverse_q;
	assign right_duty    = right_duty_q;
	assign right_reverse = right_reverse_q;
	assign left_now      = left_now_q;
	assign right_now     = right_now_q;
	assign moving        = moving_q;
	assign halted        = halted_q;

	// latched stop holds both targets at zero
	a_latch_targets_zero: assert property (@(posedge clk) disable iff (!arst_n)
		latch_q |-> (left_target_q == 9'sd0) && (right_target_q == 9'sd0))
		else $error("targets nonzero while emergency latch set");

	// latched stop holds both drives at zero
	a_latch_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		latch_q |-> (left_drive_q == 9'sd0) && (right_drive_q == 9'sd0))
		else $error("drive nonzero while emergency latch set");

	// a halted result never shows bridge drive
	a_halted_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && halted_q) |-> (left_duty_q == 8'd0) && (right_duty_q == 8'd0))
		else $error("halted result carries nonzero duty");

	// a result waiting for the sink keeps the input stage from moving on
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
		else $error("input stage advanced over a pending result");

endmodule

FILE: test/dual_motor_slew_ramp_drive_unit_test.sv
// testbench for the dual motor slew ramp drive: commands, ticks, apb setup and result checks
module dual_motor_slew_ramp_drive_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dmsr_pkg::*;

	// opcodes the block does not decode, and the register slot with nothing behind it
	localparam logic [3:0] OP_UNUSED_LO = 4'd9;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam logic [1:0] REG_UNUSED   = 2'd3;

	localparam int SETTLE_CYCLES    = 8;
	localparam int RUN_LIMIT_NS     = 4_000_000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int HOLDOFF_CYCLES   = 120;

	// one drive result as seen on the result channel
	typedef struct {
		logic [7:0]        left_duty;
		logic              left_rev;
		logic [7:0]        right_duty;
		logic              right_rev;
		logic signed [8:0] left_speed;
		logic signed [8:0] right_speed;
		logic              moving;
		logic              halted;
	} drive_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [3:0]              opcode = 4'd0;
	logic signed [8:0]       speed_a = 9'sd0;
	logic signed [8:0]       speed_b = 9'sd0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [7:0]              left_duty;
	logic                    left_reverse;
	logic [7:0]              right_duty;
	logic                    right_reverse;
	logic signed [8:0]       left_now;
	logic signed [8:0]       right_now;
	logic                    moving;
	logic                    halted;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDR_W-1:0]       paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;

	// drive state as the predictor sees it
	int tgt_left, tgt_right, cur_left, cur_right, drv_left, drv_right;
	bit latched;
	int lim_max, lim_climb, slew_step;

	drive_result_t pending_results[$];

	int send_idle_pct = 17;
	int recv_idle_pct = 82;
	int hold_left = 0;
	int mismatches = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int estop_count = 0;

	dual_motor_slew_ramp_drive_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .speed_a(speed_a), .speed_b(speed_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_duty(left_duty), .left_reverse(left_reverse),
		.right_duty(right_duty), .right_reverse(right_reverse),
		.left_now(left_now), .right_now(right_now),
		.moving(moving), .halted(halted),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	always #6 clk = ~clk;

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("** dual_motor_slew_ramp_drive_unit: FAILED **");
		$finish;
	end

	function automatic int clamp_to(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int magnitude(int v);
		return v < 0 ? -v : v;
	endfunction

	// one slew step of a current speed toward its target
	function automatic int slew_toward(int now, int goal);
		if (magnitude(goal - now) <= slew_step) return goal;
		return goal > now ? now + slew_step : now - slew_step;
	endfunction

	function automatic void reset_predictor();
		lim_max = int'(FULL_SCALE);
		lim_climb = int'(FULL_SCALE);
		slew_step = int'(RAMP_STEP_RESET);
		tgt_left = 0;
		tgt_right = 0;
		cur_left = 0;
		cur_right = 0;
		drv_left = 0;
		drv_right = 0;
		latched = 1'b0;
	endfunction

	// register write as the block stores it
	function automatic void store_register(logic [1:0] idx, logic [31:0] data);
		int v;
		v = int'(data[7:0]);
		case (idx)
			REG_MAX_SPEED: lim_max = clamp_to(v, int'(MAX_SPEED_FLOOR), int'(FULL_SCALE));
			REG_CLIMB_SPEED: lim_climb = clamp_to(v, lim_max, int'(FULL_SCALE));
			REG_RAMP_STEP: slew_step = v < int'(RAMP_STEP_MIN) ? int'(RAMP_STEP_MIN) : v;
			default: ;
		endcase
	endfunction

	function automatic int register_value(logic [1:0] idx);
		case (idx)
			REG_MAX_SPEED: return lim_max;
			REG_CLIMB_SPEED: return lim_climb;
			default: return slew_step;
		endcase
	endfunction

	// next drive state and the result it shows for one request
	function automatic drive_result_t predict_drive_step(logic [3:0] op,
			logic signed [8:0] a, logic signed [8:0] b);
		drive_result_t r;
		int sa, sb, s;
		sa = a;
		sb = b;
		s = clamp_to(sa, 0, lim_max);
		case (op)
			OP_TICK: begin
				cur_left = slew_toward(cur_left, tgt_left);
				cur_right = slew_toward(cur_right, tgt_right);
				if (!latched) begin
					drv_left = cur_left;
					drv_right = cur_right;
				end
			end
			OP_STOP: begin
				tgt_left = 0;
				tgt_right = 0;
				latched = 1'b0;
			end
			OP_FORWARD: if (!latched) begin
				tgt_left = s;
				tgt_right = s;
			end
			OP_BACKWARD: if (!latched) begin
				tgt_left = -s;
				tgt_right = -s;
			end
			OP_TURN_LEFT: if (!latched) begin
				tgt_left = -s;
				tgt_right = s;
			end
			OP_TURN_RIGHT: if (!latched) begin
				tgt_left = s;
				tgt_right = -s;
			end
			OP_CLIMB: if (!latched) begin
				tgt_left = clamp_to(sa, 0, lim_climb);
				tgt_right = tgt_left;
			end
			OP_SET_SPEEDS: if (!latched) begin
				tgt_left = clamp_to(sa, -lim_max, lim_max);
				tgt_right = clamp_to(sb, -lim_max, lim_max);
			end
			OP_ESTOP: begin
				tgt_left = 0;
				tgt_right = 0;
				cur_left = 0;
				cur_right = 0;
				drv_left = 0;
				drv_right = 0;
				latched = 1'b1;
				estop_count++;
			end
			default: ;
		endcase
		r.left_duty = 8'(clamp_to(magnitude(drv_left), 0, int'(FULL_SCALE)));
		r.left_rev = drv_left < 0;
		r.right_duty = 8'(clamp_to(magnitude(drv_right), 0, int'(FULL_SCALE)));
		r.right_rev = drv_right < 0;
		r.left_speed = 9'(cur_left);
		r.right_speed = 9'(cur_right);
		r.moving = magnitude(cur_left) > int'(MOVING_LIMIT) ||
			magnitude(cur_right) > int'(MOVING_LIMIT);
		r.halted = latched;
		return r;
	endfunction

	function automatic void flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES) $display("%s", msg);
	endfunction

	// result checking and receiver stalls
	always @(posedge clk) begin
		drive_result_t seen, want;
		if (arst_n && out_valid && out_ready) begin
			seen.left_duty = left_duty;
			seen.left_rev = left_reverse;
			seen.right_duty = right_duty;
			seen.right_rev = right_reverse;
			seen.left_speed = left_now;
			seen.right_speed = right_now;
			seen.moving = moving;
			seen.halted = halted;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result at %0t with no request pending", $realtime));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.left_duty !== seen.left_duty || want.left_rev !== seen.left_rev ||
						want.right_duty !== seen.right_duty ||
						want.right_rev !== seen.right_rev ||
						want.left_speed !== seen.left_speed ||
						want.right_speed !== seen.right_speed ||
						want.moving !== seen.moving || want.halted !== seen.halted)
					flag_mismatch($sformatf({"result %0d mismatch: expected duty %0d/%0d",
						" rev %b/%b now %0d/%0d moving %b halted %b, got duty %0d/%0d",
						" rev %b/%b now %0d/%0d moving %b halted %b"}, results_checked,
						want.left_duty, want.right_duty, want.left_rev, want.right_rev,
						want.left_speed, want.right_speed, want.moving, want.halted,
						seen.left_duty, seen.right_duty, seen.left_rev, seen.right_rev,
						seen.left_speed, seen.right_speed, seen.moving, seen.halted));
			end
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one request and record its expected result once accepted
	task automatic send_request(input logic [3:0] op, input logic signed [8:0] a,
			input logic signed [8:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		speed_a <= a;
		speed_b <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(predict_drive_step(op, a, b));
		requests_sent++;
	endtask

	// drop valid and let every pending result drain out
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		store_register(idx, data);
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [1:0] idx);
		logic [DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[7:0] !== 8'(register_value(idx)))
			flag_mismatch($sformatf("register %0d read: expected %0d, got %0d",
				idx, register_value(idx), got[7:0]));
		@(posedge clk);
	endtask

	// write all three registers, then read them back
	task automatic set_limits(input logic [31:0] max_data, input logic [31:0] climb_data,
			input logic [31:0] step_data);
		apb_write(REG_MAX_SPEED, max_data);
		apb_write(REG_CLIMB_SPEED, climb_data);
		apb_write(REG_RAMP_STEP, step_data);
		apb_read_check(REG_MAX_SPEED);
		apb_read_check(REG_CLIMB_SPEED);
		apb_read_check(REG_RAMP_STEP);
	endtask

	// register word with random upper bits; low byte often at an extreme
	function automatic logic [31:0] random_reg_word();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(5))
			0: w[7:0] = 8'd0;
			1: w[7:0] = 8'd255;
			2: w[7:0] = 8'($urandom_range(12));
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic signed [8:0] random_speed();
		case ($urandom_range(9))
			0: return 9'sh100;
			1: return -9'sd255;
			2: return 9'sd255;
			3: return 9'($urandom_range(12));
			4: return -9'($urandom_range(12));
			default: return 9'($urandom());
		endcase
	endfunction

	task automatic random_request(output logic [3:0] op, output logic signed [8:0] a,
			output logic signed [8:0] b);
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) op = OP_TICK;
		else if (pick < 78) op = 4'($urandom_range(int'(OP_SET_SPEEDS), int'(OP_FORWARD)));
		else if (pick < 86) op = OP_STOP;
		else if (pick < 91) op = OP_ESTOP;
		else op = 4'($urandom_range(int'(OP_UNUSED_HI), int'(OP_UNUSED_LO)));
		a = random_speed();
		b = random_speed();
	endtask

	// defaults after reset, then a first tick
	task automatic test_reset_state();
		apb_read_check(REG_MAX_SPEED);
		apb_read_check(REG_CLIMB_SPEED);
		apb_read_check(REG_RAMP_STEP);
		send_request(OP_TICK, 9'sd0, 9'sd0);
	endtask

	// each motion command, several at the speed extremes, plus unknown opcodes
	task automatic test_commands();
		send_request(OP_FORWARD, 9'sd255, 9'sh100);
		send_request(OP_TICK, 9'sh100, 9'sd255);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		send_request(OP_SET_SPEEDS, 9'sh100, 9'sd255);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		send_request(OP_BACKWARD, -9'sd1, 9'sd0);
		send_request(OP_TURN_LEFT, 9'sd120, -9'sd7);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		send_request(OP_TURN_RIGHT, 9'sd255, 9'sd0);
		send_request(OP_CLIMB, 9'sd255, 9'sh100);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		send_request(OP_UNUSED_LO, 9'sd255, 9'sd255);
		send_request(OP_UNUSED_HI, 9'sh100, 9'sh100);
	endtask

	// emergency stop latches, motion is ignored, stop releases
	task automatic test_emergency_latch();
		send_request(OP_ESTOP, 9'sd0, 9'sd0);
		send_request(OP_FORWARD, 9'sd200, 9'sd0);
		send_request(OP_SET_SPEEDS, 9'sd100, -9'sd100);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		send_request(OP_STOP, 9'sd0, 9'sd0);
		send_request(OP_FORWARD, 9'sd6, 9'sd0);
		send_request(OP_TICK, 9'sd0, 9'sd0);
	endtask

	// register clamping, unknown register, limits applying to later commands only
	task automatic test_register_limits();
		wait_quiet();
		set_limits(32'hFFFF_FF00, 32'h0000_0000, 32'hABCD_EF00);
		apb_write(REG_UNUSED, 32'h0000_0033);
		apb_read_check(REG_MAX_SPEED);
		send_request(OP_CLIMB, 9'sd255, 9'sd0);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		send_request(OP_SET_SPEEDS, 9'sh100, 9'sd49);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		wait_quiet();
		// climb clamps up to max; a later smaller max leaves climb alone
		set_limits(32'd200, 32'd100, 32'd255);
		apb_write(REG_MAX_SPEED, 32'd60);
		apb_read_check(REG_CLIMB_SPEED);
		send_request(OP_CLIMB, 9'sd255, 9'sd0);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		send_request(OP_FORWARD, 9'sd255, 9'sd0);
		send_request(OP_TICK, 9'sd0, 9'sd0);
		wait_quiet();
	endtask

	// random requests with occasional tick runs so the ramps settle
	task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
		logic [3:0] op;
		logic signed [8:0] a, b;
		int n, burst;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		n = 0;
		while (n < count) begin
			if ($urandom_range(9) == 0) begin
				burst = $urandom_range(30, 10);
				repeat (burst) begin
					send_request(OP_TICK, random_speed(), random_speed());
					n++;
				end
			end else begin
				random_request(op, a, b);
				send_request(op, a, b);
				n++;
			end
		end
		wait_quiet();
	endtask

	// long receiver stall while requests keep coming, so the block backs up
	task automatic test_receiver_holdoff();
		logic [3:0] op;
		logic signed [8:0] a, b;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		hold_left = HOLDOFF_CYCLES;
		repeat (60) begin
			random_request(op, a, b);
			send_request(op, a, b);
		end
		wait_quiet();
	endtask

	initial begin
		reset_predictor();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_commands();
		test_emergency_latch();
		test_register_limits();

		set_limits(random_reg_word(), random_reg_word(), 32'($urandom_range(20)));
		test_random_traffic(480, 17, 82);
		set_limits(32'd50, 32'd255, 32'd255);
		test_random_traffic(480, 82, 17);
		set_limits(random_reg_word(), random_reg_word(), random_reg_word());
		test_random_traffic(480, 0, 0);
		test_receiver_holdoff();

		wait_quiet();
		$display("run covered %0d requests, %0d results checked, %0d register writes,",
			requests_sent, results_checked, reg_writes);
		$display("%0d emergency stops, both-side stalls and a long receiver hold-off",
			estop_count);
		if (mismatches == 0) begin
			$display("** dual_motor_slew_ramp_drive_unit: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** dual_motor_slew_ramp_drive_unit: FAILED **");
		end
		$finish;
	end

endmodule
